// ===== design/iee_pkg.sv =====
// Shared types, constants and helpers for the infix expression evaluator.
`timescale 1ns / 1ps
`default_nettype none
package iee_pkg;

  localparam int OPERATOR_DEPTH = 32;
  localparam int VALUE_DEPTH    = 32;
  localparam int OCW = $clog2(OPERATOR_DEPTH + 1);
  localparam int OAW = $clog2(OPERATOR_DEPTH);
  localparam int VCW = $clog2(VALUE_DEPTH + 1);
  localparam int VAW = $clog2(VALUE_DEPTH);

  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    OP_OPEN = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_POW  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_UNDER   = 3'd1,
    ERR_OVER    = 3'd2,
    ERR_DIVZERO = 3'd3,
    ERR_BADCHAR = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    K_DIGIT = 3'd0,
    K_OPEN  = 3'd1,
    K_CLOSE = 3'd2,
    K_OP    = 3'd3,
    K_BAD   = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } sym_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         error_code;
  } res_t;

  typedef struct packed {
    kind_t      kind;
    op_t        op;
    logic [3:0] digit;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic        done;
    logic        dz;
    logic [31:0] value;
  } alu_res_t;

  function automatic logic [1:0] prec(input op_t op);
    logic [1:0] p;
    case (op)
      OP_POW:         p = 2'd3;
      OP_MUL, OP_DIV: p = 2'd2;
      OP_ADD, OP_SUB: p = 2'd1;
      default:        p = 2'd0;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== design/iee_front.sv =====
// Front end: classifies characters and queues them as commands for the back end.
`timescale 1ns / 1ps
`default_nettype none
module iee_front import iee_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic src_valid,
  output logic      src_stall,
  input  wire sym_t src_item,
  output logic      cmd_valid,
  output cmd_t      cmd,
  input  wire logic cmd_take
);

  cmd_t       q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  cmd_t       cls;
  logic       push;

  always_comb begin
    cls.last  = src_item.last;
    cls.digit = src_item.symbol[3:0];
    cls.op    = OP_OPEN;
    cls.kind  = K_OP;
    if (src_item.symbol >= CH_ZERO && src_item.symbol <= CH_NINE) begin
      cls.kind = K_DIGIT;
    end else begin
      unique case (src_item.symbol)
        CH_OPEN:  cls.kind = K_OPEN;
        CH_CLOSE: cls.kind = K_CLOSE;
        CH_ADD:   cls.op = OP_ADD;
        CH_SUB:   cls.op = OP_SUB;
        CH_MUL:   cls.op = OP_MUL;
        CH_DIV:   cls.op = OP_DIV;
        CH_POW:   cls.op = OP_POW;
        default:  cls.kind = K_BAD;
      endcase
    end
  end

  assign src_stall = (cnt == 2'd2);
  assign push      = src_valid && !src_stall;
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= cls;
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (cmd_take && cmd_valid) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(cmd_take && cmd_valid);
    end
  end

endmodule
`default_nettype wire

// ===== design/iee_alu.sv =====
// Multi-cycle arithmetic unit: add, subtract, multiply, divide and power.
`timescale 1ns / 1ps
`default_nettype none
module iee_alu import iee_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire op_t         op,
  input  wire logic [31:0] y,
  input  wire logic [31:0] x,
  output alu_res_t         res
);

  typedef enum logic [3:0] {
    AL_IDLE = 4'b0001,
    AL_DIV  = 4'b0010,
    AL_POW  = 4'b0100,
    AL_DONE = 4'b1000
  } al_state_t;

  al_state_t   state;
  logic [31:0] acc, base, ex, rem, dvsr;
  logic [4:0]  cnt;
  logic        neg, dz;
  logic [32:0] shifted, diff;

  assign shifted = {rem, acc[31]};
  assign diff    = shifted - {1'b0, dvsr};

  assign res.done  = (state == AL_DONE);
  assign res.dz    = dz;
  assign res.value = neg ? (32'd0 - acc) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= AL_IDLE;
    end else begin
      unique case (state)
        AL_IDLE: begin
          if (start) begin
            dz  <= 1'b0;
            neg <= 1'b0;
            state <= AL_DONE;
            case (op)
              OP_ADD: acc <= y + x;
              OP_SUB: acc <= y - x;
              OP_MUL: acc <= y * x;
              OP_DIV: begin
                if (x == 32'd0) begin
                  dz <= 1'b1;
                end else begin
                  acc   <= y[31] ? (32'd0 - y) : y;
                  dvsr  <= x[31] ? (32'd0 - x) : x;
                  rem   <= 32'd0;
                  cnt   <= 5'd0;
                  neg   <= x[31] ^ y[31];
                  state <= AL_DIV;
                end
              end
              OP_POW: begin
                if (x[31]) begin
                  // Negative exponent: only bases 1 and -1 survive.
                  if (y == 32'd1) acc <= 32'd1;
                  else if (y == 32'hFFFF_FFFF) acc <= x[0] ? 32'hFFFF_FFFF : 32'd1;
                  else begin
                    acc <= 32'd0;
                    dz  <= (y == 32'd0);
                  end
                end else begin
                  acc   <= 32'd1;
                  base  <= y;
                  ex    <= x;
                  state <= AL_POW;
                end
              end
              default: acc <= 32'd0;
            endcase
          end
        end
        AL_DIV: begin
          if (!diff[32]) begin
            rem <= diff[31:0];
            acc <= {acc[30:0], 1'b1};
          end else begin
            rem <= shifted[31:0];
            acc <= {acc[30:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) state <= AL_DONE;
        end
        AL_POW: begin
          if (ex == 32'd0) begin
            state <= AL_DONE;
          end else begin
            if (ex[0]) acc <= acc * base;
            base <= base * base;
            ex   <= ex >> 1;
          end
        end
        AL_DONE: state <= AL_IDLE;
        default: state <= AL_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/iee_back.sv =====
// Back end: operator and value stacks with the sequencer that evaluates commands.
`timescale 1ns / 1ps
`default_nettype none
module iee_back import iee_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd_in,
  output logic      cmd_take,
  output logic      dst_valid,
  input  wire logic dst_stall,
  output res_t      dst_item
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_ORD  = 9'b000000010,
    S_OCHK = 9'b000000100,
    S_A0   = 9'b000001000,
    S_A1   = 9'b000010000,
    S_A2   = 9'b000100000,
    S_AW   = 9'b001000000,
    S_FR   = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  typedef enum logic [2:0] {
    M_CLOSE = 3'b001,
    M_OP    = 3'b010,
    M_FLUSH = 3'b100
  } mode_t;

  state_t state, state_next;
  mode_t  mode, mode_next;
  cmd_t   cmd, cmd_next;
  logic [OCW-1:0] ocount, ocount_next;
  logic [VCW-1:0] vcount, vcount_next;
  err_t   err, err_next;
  op_t    cur_op, cur_op_next;
  logic [31:0] xreg, xreg_next;
  logic   out_valid, out_valid_next;
  res_t   out_data, out_data_next;

  logic [2:0]  omem [OPERATOR_DEPTH];
  logic [31:0] vmem [VALUE_DEPTH];
  logic           o_we, v_we;
  logic [OAW-1:0] o_waddr, o_raddr;
  logic [VAW-1:0] v_waddr, v_raddr;
  logic [2:0]     o_wdata, o_rdata;
  logic [31:0]    v_wdata, v_rdata;
  op_t            top;

  logic     alu_start;
  alu_res_t alu;

  iee_alu u_alu (
    .clk   (clk),
    .rst   (rst),
    .start (alu_start),
    .op    (cur_op),
    .y     (v_rdata),
    .x     (xreg),
    .res   (alu)
  );

  assign top       = op_t'(o_rdata);
  assign dst_valid = out_valid;
  assign dst_item  = out_data;

  always_ff @(posedge clk) begin
    if (o_we) omem[o_waddr] <= o_wdata;
    o_rdata <= omem[o_raddr];
    if (v_we) vmem[v_waddr] <= v_wdata;
    v_rdata <= vmem[v_raddr];
  end

  always_comb begin
    state_next     = state;
    mode_next      = mode;
    cmd_next       = cmd;
    ocount_next    = ocount;
    vcount_next    = vcount;
    err_next       = err;
    cur_op_next    = cur_op;
    xreg_next      = xreg;
    out_valid_next = out_valid && dst_stall;
    out_data_next  = out_data;
    cmd_take       = 1'b0;
    alu_start      = 1'b0;
    o_we    = 1'b0;
    o_waddr = ocount[OAW-1:0];
    o_wdata = OP_OPEN;
    o_raddr = ocount[OAW-1:0] - OAW'(1);
    v_we    = 1'b0;
    v_waddr = vcount[VAW-1:0];
    v_wdata = 32'd0;
    v_raddr = vcount[VAW-1:0] - VAW'(1);

    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_take   = 1'b1;
          cmd_next   = cmd_in;
          state_next = S_IDLE;
          if (cmd_in.last) begin
            mode_next  = M_FLUSH;
            state_next = S_ORD;
          end
          if (err == ERR_NONE) begin
            case (cmd_in.kind)
              K_DIGIT: begin
                if (vcount == VCW'(VALUE_DEPTH)) err_next = ERR_OVER;
                else begin
                  v_we        = 1'b1;
                  v_wdata     = {28'd0, cmd_in.digit};
                  vcount_next = vcount + VCW'(1);
                end
              end
              K_OPEN: begin
                if (ocount == OCW'(OPERATOR_DEPTH)) err_next = ERR_OVER;
                else begin
                  o_we        = 1'b1;
                  ocount_next = ocount + OCW'(1);
                end
              end
              K_CLOSE: begin
                mode_next  = M_CLOSE;
                state_next = S_ORD;
              end
              K_OP: begin
                mode_next  = M_OP;
                state_next = S_ORD;
              end
              default: err_next = ERR_BADCHAR;
            endcase
          end
        end
      end
      S_ORD: begin
        if (err != ERR_NONE || ocount == '0) begin
          // The pop loop is over; finish the command that started it.
          state_next = S_IDLE;
          if (mode == M_OP && err == ERR_NONE) begin
            if (ocount == OCW'(OPERATOR_DEPTH)) err_next = ERR_OVER;
            else begin
              o_we        = 1'b1;
              o_wdata     = cmd.op;
              ocount_next = ocount + OCW'(1);
            end
          end
          if (mode == M_FLUSH) state_next = S_FR;
          else if (cmd.last) begin
            mode_next  = M_FLUSH;
            state_next = S_ORD;
          end
        end else begin
          state_next = S_OCHK;
        end
      end
      S_OCHK: begin
        state_next = S_A0;
        case (mode)
          M_CLOSE: begin
            ocount_next = ocount - OCW'(1);
            cur_op_next = top;
            if (top == OP_OPEN) begin
              state_next = S_IDLE;
              if (cmd.last) begin
                mode_next  = M_FLUSH;
                state_next = S_ORD;
              end
            end
          end
          M_OP: begin
            if (prec(cmd.op) <= prec(top)) begin
              ocount_next = ocount - OCW'(1);
              cur_op_next = top;
            end else begin
              state_next = S_IDLE;
              if (ocount == OCW'(OPERATOR_DEPTH)) err_next = ERR_OVER;
              else begin
                o_we        = 1'b1;
                o_wdata     = cmd.op;
                ocount_next = ocount + OCW'(1);
              end
              if (cmd.last) begin
                mode_next  = M_FLUSH;
                state_next = S_ORD;
              end
            end
          end
          default: begin
            ocount_next = ocount - OCW'(1);
            cur_op_next = top;
            if (top == OP_OPEN) state_next = S_ORD;
          end
        endcase
      end
      S_A0: begin
        if (vcount < VCW'(2)) begin
          err_next   = ERR_UNDER;
          state_next = S_ORD;
        end else begin
          state_next = S_A1;
        end
      end
      S_A1: begin
        xreg_next  = v_rdata;
        v_raddr    = vcount[VAW-1:0] - VAW'(2);
        state_next = S_A2;
      end
      S_A2: begin
        alu_start   = 1'b1;
        vcount_next = vcount - VCW'(2);
        state_next  = S_AW;
      end
      S_AW: begin
        if (alu.done) begin
          if (alu.dz) err_next = ERR_DIVZERO;
          else begin
            v_we        = 1'b1;
            v_wdata     = alu.value;
            vcount_next = vcount + VCW'(1);
          end
          state_next = S_ORD;
        end
      end
      S_FR: begin
        if (err == ERR_NONE && vcount == '0) err_next = ERR_UNDER;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || !dst_stall) begin
          out_valid_next           = 1'b1;
          out_data_next.value      = (err != ERR_NONE) ? 32'sd0 : $signed(v_rdata);
          out_data_next.error_code = err;
          ocount_next = '0;
          vcount_next = '0;
          err_next    = ERR_NONE;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cmd      <= cmd_next;
    cur_op   <= cur_op_next;
    xreg     <= xreg_next;
    out_data <= out_data_next;
    mode     <= mode_next;
    if (rst) begin
      state     <= S_IDLE;
      ocount    <= '0;
      vcount    <= '0;
      err       <= ERR_NONE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ocount    <= ocount_next;
      vcount    <= vcount_next;
      err       <= err_next;
      out_valid <= out_valid_next;
    end
  end

  a_ocount_range: assert property (@(posedge clk) disable iff (rst)
    ocount <= OCW'(OPERATOR_DEPTH)) else $error("operator count beyond depth");
  a_vcount_range: assert property (@(posedge clk) disable iff (rst)
    vcount <= VCW'(VALUE_DEPTH)) else $error("value count beyond depth");
  a_fin_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && (!out_valid || !dst_stall)) |=>
      (ocount == '0 && vcount == '0 && err == ERR_NONE && out_valid))
    else $error("final result did not clear the evaluator");
  a_alu_wait: assert property (@(posedge clk) disable iff (rst)
    alu.done |-> state == S_AW) else $error("arithmetic result with no request waiting");

endmodule
`default_nettype wire

// ===== design/infix_expression_evaluator_top.sv =====
// Top level of the infix expression evaluator: front end, command queue and back end.
// A digit or '(' passes through the command queue and is pushed onto its stack by the back end;
// each operator applied passes through states S_ORD, S_OCHK, S_A0, S_A1, S_A2 and S_AW, where the
// arithmetic unit computes + - * directly, / by restoring division and ^ by square-and-multiply.
// The final character adds the flush of all pending operators, then S_FR and S_FIN give the result.
// Reset (rst, synchronous, active high) empties both stacks, the queue and the error latch.
`timescale 1ns / 1ps
`default_nettype none
module infix_expression_evaluator_top import iee_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic src_valid,
  output logic      src_stall,
  input  wire sym_t src_item,
  output logic      dst_valid,
  input  wire logic dst_stall,
  output res_t      dst_item
);

  logic cmd_valid, cmd_take;
  cmd_t cmd;

  iee_front u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_item  (src_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  iee_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_in    (cmd),
    .cmd_take  (cmd_take),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_item  (dst_item)
  );

endmodule
`default_nettype wire
